FILE: hdl/cdq_pkg.sv
// Shared types and defaults for the circular deque.
package cdq_pkg;

    localparam int CDQ_DEPTH     = 16;
    localparam int CDQ_WORD_BITS = 32;
    localparam int FIELD_BITS    = 32;

    typedef enum logic [1:0] {
        KIND_PUSH_BACK,
        KIND_PUSH_FRONT,
        KIND_POP_FRONT,
        KIND_POP_BACK
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_DONE,
        STATUS_OVERFLOW,
        STATUS_UNDERFLOW
    } status_t;

endpackage

FILE: hdl/cdq_ring_mem.sv
// Ring storage: one write port and one registered read port.
module cdq_ring_mem
    import cdq_pkg::*;
#(
    parameter int DEPTH     = CDQ_DEPTH,
    parameter int WORD_BITS = CDQ_WORD_BITS,
    localparam int PTR_BITS = $clog2(DEPTH)
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [PTR_BITS-1:0]  waddr,
    input  logic [WORD_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [PTR_BITS-1:0]  raddr,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] ring_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ring_mem[waddr] <= wdata;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= ring_mem[raddr];
        end
    end

endmodule

FILE: hdl/circular_deque_unit.sv
// Circular deque top level: pointer and count control around the ring memory.
// Latency: the result strobe (done) rises in the cycle after start is taken.
// Busy: no new operation is taken while a result is shown; the result cycle
//   waits on the registered read port of the ring memory that refills the front/back cache.
// Reset (rst_n low, asynchronous): queue empty, pointers zero, block idle.
// The receiver cannot stall: every result is valid for exactly one cycle.
module circular_deque_unit
    import cdq_pkg::*;
#(
    parameter int DEPTH       = CDQ_DEPTH,
    parameter int WORD_BITS   = CDQ_WORD_BITS,
    localparam int PTR_BITS   = $clog2(DEPTH),
    localparam int COUNT_BITS = $clog2(DEPTH + 1)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   kind,
    input  logic signed [FIELD_BITS-1:0] value,
    output logic                         done,
    output logic [1:0]                   status,
    output logic signed [FIELD_BITS-1:0] popped_value,
    output logic signed [FIELD_BITS-1:0] front_value,
    output logic signed [FIELD_BITS-1:0] back_value,
    output logic [COUNT_BITS-1:0]        occupancy
);

    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } state_t;

    localparam logic [PTR_BITS-1:0]   LAST_PTR  = PTR_BITS'(DEPTH - 1);
    localparam logic [COUNT_BITS-1:0] FULL_CNT  = COUNT_BITS'(DEPTH);
    localparam logic [COUNT_BITS-1:0] TWO_CNT   = COUNT_BITS'(2);

    state_t               state_reg;
    logic [PTR_BITS-1:0]  head_reg,  head_next;
    logic [PTR_BITS-1:0]  tail_reg,  tail_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    // Cached words at the two ends; valid when the queue is not empty, but for a pending refill.
    logic [WORD_BITS-1:0] front_reg, front_next;
    logic [WORD_BITS-1:0] back_reg,  back_next;
    // Set when the new end word must come from the ring read port.
    logic                 fix_front_reg, fix_front_next;
    logic                 fix_back_reg,  fix_back_next;

    status_t              status_reg,  status_next;
    logic [WORD_BITS-1:0] popped_reg,  popped_next;

    logic                 accept;
    logic                 full;
    logic                 empty;
    logic [WORD_BITS-1:0] word_in;
    logic [PTR_BITS-1:0]  head_inc, head_dec, tail_inc, tail_dec, tail_dec2;

    logic                 mem_we;
    logic [PTR_BITS-1:0]  mem_waddr;
    logic                 mem_re;
    logic [PTR_BITS-1:0]  mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    logic [WORD_BITS-1:0] front_cur;
    logic [WORD_BITS-1:0] back_cur;

    assign busy    = (state_reg == ST_RESP);
    assign accept  = start && !busy;
    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign word_in = WORD_BITS'($unsigned(value));

    // Ring neighbors; wrap explicitly so any depth works.
    assign head_inc  = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
    assign head_dec  = (head_reg == '0) ? LAST_PTR : head_reg - 1'b1;
    assign tail_inc  = (tail_reg == LAST_PTR) ? '0 : tail_reg + 1'b1;
    assign tail_dec  = (tail_reg == '0) ? LAST_PTR : tail_reg - 1'b1;
    assign tail_dec2 = (tail_dec == '0) ? LAST_PTR : tail_dec - 1'b1;

    // Decode one operation: update pointers and count, write a pushed word,
    // and start a read when a pop exposes an end word not held in the cache.
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        front_next     = front_reg;
        back_next      = back_reg;
        fix_front_next = 1'b0;
        fix_back_next  = 1'b0;
        status_next    = STATUS_DONE;
        popped_next    = '0;
        mem_we         = 1'b0;
        mem_waddr      = tail_reg;
        mem_re         = 1'b0;
        mem_raddr      = head_inc;

        if (accept)
        begin
            unique case (kind_t'(kind))
                KIND_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = STATUS_OVERFLOW;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = tail_reg;
                        tail_next  = tail_inc;
                        count_next = count_reg + 1'b1;
                        back_next  = word_in;
                        if (empty)
                        begin
                            front_next = word_in;
                        end
                    end
                end
                KIND_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = STATUS_OVERFLOW;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = head_dec;
                        head_next  = head_dec;
                        count_next = count_reg + 1'b1;
                        front_next = word_in;
                        if (empty)
                        begin
                            back_next = word_in;
                        end
                    end
                end
                KIND_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = STATUS_UNDERFLOW;
                    end
                    else
                    begin
                        popped_next = front_reg;
                        head_next   = head_inc;
                        count_next  = count_reg - 1'b1;
                        if (count_reg == TWO_CNT)
                        begin
                            front_next = back_reg;
                        end
                        else if (count_reg > TWO_CNT)
                        begin
                            mem_re         = 1'b1;
                            mem_raddr      = head_inc;
                            fix_front_next = 1'b1;
                        end
                    end
                end
                KIND_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = STATUS_UNDERFLOW;
                    end
                    else
                    begin
                        popped_next = back_reg;
                        tail_next   = tail_dec;
                        count_next  = count_reg - 1'b1;
                        if (count_reg == TWO_CNT)
                        begin
                            back_next = front_reg;
                        end
                        else if (count_reg > TWO_CNT)
                        begin
                            mem_re        = 1'b1;
                            mem_raddr     = tail_dec2;
                            fix_back_next = 1'b1;
                        end
                    end
                end
                default:
                begin
                    status_next = STATUS_DONE;
                end
            endcase
        end
    end

    // During the result cycle, take the refilled end word from the read port.
    assign front_cur = fix_front_reg ? mem_rdata : front_reg;
    assign back_cur  = fix_back_reg  ? mem_rdata : back_reg;

    // Control state, pointers, end-word cache and registered result fields.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            fix_front_reg <= 1'b0;
            fix_back_reg  <= 1'b0;
            front_reg     <= '0;
            back_reg      <= '0;
            status_reg    <= STATUS_DONE;
            popped_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg     <= ST_RESP;
                        head_reg      <= head_next;
                        tail_reg      <= tail_next;
                        count_reg     <= count_next;
                        fix_front_reg <= fix_front_next;
                        fix_back_reg  <= fix_back_next;
                        front_reg     <= front_next;
                        back_reg      <= back_next;
                        status_reg    <= status_next;
                        popped_reg    <= popped_next;
                    end
                end
                ST_RESP:
                begin
                    state_reg     <= ST_IDLE;
                    fix_front_reg <= 1'b0;
                    fix_back_reg  <= 1'b0;
                    front_reg     <= front_cur;
                    back_reg      <= back_cur;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    cdq_ring_mem #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_ring_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (word_in),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Present the transfer for exactly one cycle; ends read as zero when empty.
    assign done         = busy;
    assign status       = status_reg;
    assign popped_value = FIELD_BITS'(popped_reg);
    assign front_value  = (count_reg == '0) ? '0 : FIELD_BITS'(front_cur);
    assign back_value   = (count_reg == '0) ? '0 : FIELD_BITS'(back_cur);
    assign occupancy    = count_reg;

endmodule
